### src/char_lcd_write_sequencer_assert.svh
// Assertion macros for the character LCD write sequencer.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define LCDWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, also while reset is held.
`define LCDWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/lcdws_pkg.sv
// Shared types and constants for the character LCD write sequencer.
// No dependencies; imported by every module of the block.
package lcdws_pkg;

  // Command codes carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_INSTR  = 2'd0,
    OP_DATA   = 2'd1,
    OP_CURSOR = 2'd2
  } lcdws_op_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_BUS_8BIT   = 3'd0;
  localparam logic [2:0] REG_SETUP_US   = 3'd1;
  localparam logic [2:0] REG_PULSE_US   = 3'd2;
  localparam logic [2:0] REG_SETTLE_US  = 3'd3;
  localparam logic [2:0] REG_LONG_WAIT  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic        RST_BUS_8BIT   = 1'b0;
  localparam logic [7:0]  RST_SETUP_US   = 8'd1;
  localparam logic [7:0]  RST_PULSE_US   = 8'd1;
  localparam logic [9:0]  RST_SETTLE_US  = 10'd45;
  localparam logic [15:0] RST_LONG_WAIT  = 16'd5000;

  // Display geometry defaults.
  localparam int DEF_COLUMNS = 16;
  localparam int DEF_ROWS    = 2;

  // DDRAM address base of each row, and the limit below which an
  // instruction (clear or home) needs the long wait.
  localparam logic [7:0]  ADDR_ROW0       = 8'h80;
  localparam logic [7:0]  ADDR_ROW1       = 8'hC0;
  localparam logic [7:0]  LONG_INSTR_LIM  = 8'd4;
  localparam logic [15:0] WAIT_MAX        = 16'hFFFF;

  // Command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        bus_8bit;
    logic [7:0]  setup_us;
    logic [7:0]  pulse_us;
    logic [9:0]  settle_us;
    logic [15:0] long_wait_us;
  } lcdws_cfg_t;

  // One classified command, ready to be turned into pin steps.
  typedef struct packed {
    logic        rs;
    logic [7:0]  bus_byte;
    logic [15:0] final_wait;
  } lcdws_cmd_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic       empty;
    lcdws_cmd_t head;
  } lcdws_qhead_t;

endpackage

### src/char_lcd_write_sequencer.sv
// Top level of the character LCD write sequencer: configuration registers,
// front end, command queue and pin-step back end. Depends on lcdws_pkg,
// lcdws_front, lcdws_queue, lcdws_back and the assertion macro header.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tuser: op; tdata: value, column, row
//   m_axis    out        m_axis_tvalid/tready       tuser: reg_select; tdata: enable,
//                                                   data_bus, wait_us; tlast: last
//   cfg       in         cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// Each command becomes three pin steps on an 8-bit bus and six on a 4-bit bus;
// the output register issues one step per cycle unless stalled on m_axis_tready.
// Invalid commands are taken and dropped without reaching the queue.
// A two-entry queue lets the front end take new items while the back end is
// still stepping or stalled on m_axis_tready. Reset is asynchronous and clears
// the control state and restores the configuration defaults; no clearing pass.
`include "char_lcd_write_sequencer_assert.svh"

module char_lcd_write_sequencer
  import lcdws_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] value, [12:8] column, [14:13] row, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] enable_pin, [8:1] data_bus, [24:9] wait_us,
                                      // [31:25] zero
  output logic        m_axis_tuser,   // [0] reg_select
  output logic        m_axis_tlast,   // last step of the command

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers. The user must write them only while the block is
  // idle (the block does not enforce this), so both ends read them directly.
  lcdws_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_8bit     <= RST_BUS_8BIT;
      cfg_q.setup_us     <= RST_SETUP_US;
      cfg_q.pulse_us     <= RST_PULSE_US;
      cfg_q.settle_us    <= RST_SETTLE_US;
      cfg_q.long_wait_us <= RST_LONG_WAIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BUS_8BIT:  cfg_q.bus_8bit     <= cfg_data_i[0];
        REG_SETUP_US:  cfg_q.setup_us     <= cfg_data_i[7:0];
        REG_PULSE_US:  cfg_q.pulse_us     <= cfg_data_i[7:0];
        REG_SETTLE_US: cfg_q.settle_us    <= cfg_data_i[9:0];
        REG_LONG_WAIT: cfg_q.long_wait_us <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic             q_full;
  logic             push;
  logic             pop;
  lcdws_cmd_t       cmd;
  lcdws_qhead_t     qhead;
  logic [CNT_W-1:0] q_count;
  logic             enable_pin;
  logic [7:0]       data_bus;
  logic [15:0]      wait_us;

  // The front end classifies the item in the accepting cycle and pushes
  // only commands that produce pin steps.
  lcdws_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .value_i    (s_axis_tdata[7:0]),
    .column_i   (s_axis_tdata[12:8]),
    .row_i      (s_axis_tdata[14:13]),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  lcdws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .head_o  (qhead),
    .count_o (q_count)
  );

  // The back end pops a command when it issues that command's last step.
  lcdws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (qhead),
    .cfg_i        (cfg_q),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .reg_select_o (m_axis_tuser),
    .enable_pin_o (enable_pin),
    .data_bus_o   (data_bus),
    .wait_us_o    (wait_us),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, wait_us, data_bus, enable_pin};

  // Queue occupancy never exceeds its depth.
  `LCDWS_ASSERT(a_queue_bound, q_count <= CNT_W'(QUEUE_DEPTH), "queue overflow")
  // A command is only retired while one is queued.
  `LCDWS_ASSERT(a_pop_nonempty, pop |-> (q_count != '0), "pop from empty queue")
  // On a 4-bit bus the upper data pins stay low.
  `LCDWS_ASSERT(a_nibble_upper, (m_axis_tvalid && !cfg_q.bus_8bit) |-> (data_bus[7:4] == 4'h0),
    "upper data pins driven in 4-bit mode")
  // Once reset has been seen at an edge, no step is offered at the next one.
  `LCDWS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

endmodule

### src/lcdws_front.sv
// Front end: accepts commands, drops invalid ones, resolves the byte and
// final wait. Depends on lcdws_pkg.
module lcdws_front
  import lcdws_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  value_i,
  input  logic [4:0]  column_i,
  input  logic [1:0]  row_i,
  input  lcdws_cfg_t  cfg_i,
  input  logic        q_full_i,
  output logic        push_o,
  output lcdws_cmd_t  cmd_o
);

  logic        keep;
  logic        rs;
  logic [7:0]  bus_byte;
  logic        in_range;
  logic [16:0] wait_sum;

  assign in_range = ({2'b00, column_i} < 7'(COLUMNS)) && (row_i < 2'(ROWS));

  always_comb begin
    keep     = 1'b0;
    rs       = 1'b0;
    bus_byte = value_i;
    case (op_i)
      OP_INSTR: begin
        keep = 1'b1;
      end
      OP_DATA: begin
        keep = 1'b1;
        rs   = 1'b1;
      end
      OP_CURSOR: begin
        keep     = in_range;
        bus_byte = ((row_i != 2'd0) ? ADDR_ROW1 : ADDR_ROW0) + {3'b000, column_i};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Clear and home add the long wait to the final settle time.
  always_comb begin
    wait_sum = {7'd0, cfg_i.settle_us};
    if (!rs && (bus_byte < LONG_INSTR_LIM)) begin
      wait_sum = wait_sum + {1'b0, cfg_i.long_wait_us};
    end
  end

  assign cmd_o.rs         = rs;
  assign cmd_o.bus_byte   = bus_byte;
  assign cmd_o.final_wait = wait_sum[16] ? WAIT_MAX : wait_sum[15:0];

  assign s_tready_o = !q_full_i;
  assign push_o     = s_tvalid_i && !q_full_i && keep;

endmodule

### src/lcdws_queue.sv
// Short command queue decoupling the front end from the pin sequencer.
// Depends on lcdws_pkg.
module lcdws_queue
  import lcdws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lcdws_cmd_t   cmd_i,
  input  logic         pop_i,
  output logic         full_o,
  output lcdws_qhead_t head_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lcdws_cmd_t       entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.empty = (count_q == '0);
  assign head_o.head  = entry_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

### src/lcdws_back.sv
// Back end: walks the queued command through its setup, strobe and settle
// steps into a registered output stage. Depends on lcdws_pkg.
module lcdws_back
  import lcdws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lcdws_qhead_t q_i,
  input  lcdws_cfg_t   cfg_i,
  output logic         pop_o,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic         reg_select_o,
  output logic         enable_pin_o,
  output logic [7:0]   data_bus_o,
  output logic [15:0]  wait_us_o,
  output logic         last_o
);

  localparam logic [1:0] SUB_SETUP  = 2'd0;
  localparam logic [1:0] SUB_PULSE  = 2'd1;
  localparam logic [1:0] SUB_SETTLE = 2'd2;

  logic [1:0]  sub_q, sub_d;
  logic        phase_q, phase_d;   // 0 high nibble (or full byte), 1 low nibble
  logic        valid_q, valid_d;
  logic        load;
  logic        final_triple;
  logic        step_en, step_last;
  logic [7:0]  step_bus;
  logic [15:0] step_wait;
  logic        rs_q, en_q, last_q;
  logic [7:0]  bus_q;
  logic [15:0] wait_q;

  assign load         = !q_i.empty && (!valid_q || m_tready_i);
  assign final_triple = cfg_i.bus_8bit || phase_q;

  always_comb begin
    step_en   = 1'b0;
    step_last = 1'b0;
    step_wait = {8'd0, cfg_i.setup_us};
    case (sub_q)
      SUB_SETUP: begin
        step_wait = {8'd0, cfg_i.setup_us};
      end
      SUB_PULSE: begin
        step_en   = 1'b1;
        step_wait = {8'd0, cfg_i.pulse_us};
      end
      SUB_SETTLE: begin
        step_last = final_triple;
        step_wait = final_triple ? q_i.head.final_wait : {6'd0, cfg_i.settle_us};
      end
      default: begin
        step_wait = {8'd0, cfg_i.setup_us};
      end
    endcase
    if (cfg_i.bus_8bit) begin
      step_bus = q_i.head.bus_byte;
    end else if (phase_q) begin
      step_bus = {4'h0, q_i.head.bus_byte[3:0]};
    end else begin
      step_bus = {4'h0, q_i.head.bus_byte[7:4]};
    end
  end

  always_comb begin
    sub_d   = sub_q;
    phase_d = phase_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      if (sub_q == SUB_SETTLE) begin
        sub_d   = SUB_SETUP;
        phase_d = step_last ? 1'b0 : 1'b1;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= SUB_SETUP;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= q_i.head.rs;
      en_q   <= step_en;
      bus_q  <= step_bus;
      wait_q <= step_wait;
      last_q <= step_last;
    end
  end

  assign pop_o        = load && step_last;
  assign m_tvalid_o   = valid_q;
  assign reg_select_o = rs_q;
  assign enable_pin_o = en_q;
  assign data_bus_o   = bus_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule
